### rtl/tkec_pkg.sv
// Shared types and constants for the touch key event classifier.
// Used by the front, back and top modules; depends on nothing else.
package tkec_pkg;

    // Fixed sizes from the item formats
    localparam int MAX_SLOTS   = 8;
    localparam int MASK_W      = MAX_SLOTS + 1;
    localparam int STATUS_W    = 12;
    localparam int TIME_W      = 32;
    localparam int HOLD_W      = 16;
    localparam int BUTTON_IRQ_POS = 2;
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_BUTTON_ENABLE = 1'b0;
    localparam logic REG_LONG_HOLD     = 1'b1;
    localparam logic [MAX_SLOTS-1:0] ENABLE_RESET = 8'hFF;
    localparam logic [HOLD_W-1:0]    HOLD_RESET   = 16'd1000;

    // One input item: a poll of the controller
    typedef struct packed {
        logic                irq_seen;
        logic [7:0]          irq_source;
        logic [STATUS_W-1:0] cap_status;
        logic [TIME_W-1:0]   now_ms;
    } poll_t;

    // One result item
    typedef struct packed {
        logic [MASK_W-1:0] tap_bits;
        logic [MASK_W-1:0] rel_bits;
        logic [MASK_W-1:0] long_tap_bits;
        logic [MASK_W-1:0] long_rel_bits;
    } result_t;

    // Configuration seen by front and back
    typedef struct packed {
        logic [MAX_SLOTS-1:0] button_enable;
        logic [HOLD_W-1:0]    long_hold_ms;
    } cfg_t;

    // Poll mapped onto slots, queued between front and back
    typedef struct packed {
        logic                 irq;
        logic [MAX_SLOTS-1:0] touch;
        logic [MAX_SLOTS-1:0] active;
        logic [TIME_W-1:0]    now_ms;
    } slot_item_t;

endpackage

### rtl/tkec_fifo.sv
// Small first-word-fall-through queue built from registers.
// Used between front and back and on the result side; no package needed.
module tkec_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### rtl/tkec_front.sv
// Front end: masks the status by the interrupt source and maps enabled
// channels onto slots. Depends on tkec_pkg.
module tkec_front #(
    parameter int NUM_BUTTONS = 8
) (
    input  tkec_pkg::cfg_t       cfg,
    input  tkec_pkg::poll_t      poll,
    output tkec_pkg::slot_item_t item
);
    import tkec_pkg::*;

    logic [STATUS_W-1:0]  status_eff;
    logic [3:0]           slot_idx [NUM_BUTTONS];
    logic [3:0]           active_cnt;
    logic [MAX_SLOTS-1:0] touch;
    logic [MAX_SLOTS-1:0] active;

    // Status reads as all untouched without a button interrupt
    assign status_eff = poll.irq_source[BUTTON_IRQ_POS] ? poll.cap_status : '0;

    // Slot of each channel: number of enabled channels below it
    always_comb
    begin
        for (int p = 0; p < NUM_BUTTONS; p++)
        begin
            slot_idx[p] = '0;
            for (int q = 0; q < p; q++)
            begin
                slot_idx[p] = slot_idx[p] + 4'(cfg.button_enable[q]);
            end
        end
    end

    // Gather touch bits per slot, and the run of active slots
    always_comb
    begin
        touch      = '0;
        active_cnt = '0;
        for (int p = 0; p < NUM_BUTTONS; p++)
        begin
            active_cnt = active_cnt + 4'(cfg.button_enable[p]);
            for (int s = 0; s < NUM_BUTTONS; s++)
            begin
                if (cfg.button_enable[p] && slot_idx[p] == 4'(s))
                begin
                    touch[s] = status_eff[p];
                end
            end
        end
        for (int s = 0; s < MAX_SLOTS; s++)
        begin
            active[s] = (4'(s) < active_cnt);
        end
    end

    assign item.irq    = poll.irq_seen;
    assign item.touch  = touch;
    assign item.active = active;
    assign item.now_ms = poll.now_ms;

endmodule

### rtl/tkec_back.sv
// Back end: per-slot press tracking lanes that produce the event masks.
// Depends on tkec_pkg.
module tkec_back #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tkec_pkg::cfg_t       cfg,
    input  tkec_pkg::slot_item_t item,
    input  logic                 item_valid,
    input  logic                 out_full,
    output logic                 item_pop,
    output tkec_pkg::result_t    result,
    output logic                 result_push
);
    import tkec_pkg::*;

    logic [NUM_BUTTONS-1:0] touched_reg, touched_next;
    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic [NUM_BUTTONS-1:0] lrep_reg, lrep_next;
    logic [TIME_W-1:0]      press_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]      press_next [NUM_BUTTONS];
    logic [MASK_W-1:0]      tap, rel, ltap, lrel;
    logic [TIME_W-1:0]      elapsed [NUM_BUTTONS];
    logic                   tn, over;

    assign item_pop = item_valid && !out_full;

    // Lanes: one per slot, all working on the same item
    always_comb
    begin
        touched_next = touched_reg;
        held_next    = held_reg;
        lrep_next    = lrep_reg;
        press_next   = press_reg;
        tap  = '0;
        rel  = '0;
        ltap = '0;
        lrel = '0;
        tn   = 1'b0;
        over = 1'b0;
        for (int s = 0; s < NUM_BUTTONS; s++)
        begin
            elapsed[s] = item.now_ms - press_reg[s];
            if (item.active[s])
            begin
                tn   = item.irq ? item.touch[s] : touched_reg[s];
                over = elapsed[s] > TIME_W'(cfg.long_hold_ms);
                touched_next[s] = tn;
                if (!held_reg[s] && tn)
                begin
                    held_next[s]  = 1'b1;
                    press_next[s] = item.now_ms;
                    lrep_next[s]  = 1'b0;
                    tap[s+1]      = 1'b1;
                end
                else if (!tn && held_reg[s])
                begin
                    held_next[s] = 1'b0;
                    lrep_next[s] = 1'b0;
                    if (over)
                    begin
                        lrel[s+1] = 1'b1;
                    end
                    else
                    begin
                        rel[s+1] = 1'b1;
                    end
                end
                else if (!lrep_reg[s] && tn && over)
                begin
                    lrep_next[s] = 1'b1;
                    ltap[s+1]    = 1'b1;
                end
            end
        end
    end

    assign result.tap_bits      = tap;
    assign result.rel_bits      = rel;
    assign result.long_tap_bits = ltap;
    assign result.long_rel_bits = lrel;
    assign result_push = item_pop && ((tap | rel | ltap | lrel) != '0);

    // Slot state commits when an item is taken from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_reg <= '0;
            held_reg    <= '0;
            lrep_reg    <= '0;
            for (int s = 0; s < NUM_BUTTONS; s++)
            begin
                press_reg[s] <= '0;
            end
        end
        else if (item_pop)
        begin
            touched_reg <= touched_next;
            held_reg    <= held_next;
            lrep_reg    <= lrep_next;
            press_reg   <= press_next;
        end
    end

    // A long tap is only ever flagged during a press
    a_lrep_held: assert property (@(posedge clk) disable iff (!rst_n)
        (lrep_reg & ~held_reg) == '0)
        else $error("long report flag set on a slot that is not held");

    // A result carries at least one event and never uses bit 0
    a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_push |-> ((tap | rel | ltap | lrel) != '0) &&
                        !(tap[0] || rel[0] || ltap[0] || lrel[0]))
        else $error("bad result pushed");

    // A slot reports at most one event per item
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> ((tap & (rel | ltap | lrel)) == '0) &&
                     ((rel & (ltap | lrel)) == '0) && ((ltap & lrel) == '0))
        else $error("slot reported two events in one item");

    // Items leave the queue only when the result side has room
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid && !out_full)
        else $error("item taken without room for its result");

endmodule

### rtl/touch_key_event_classifier.sv
// Touch key event classifier, top level. Depends on tkec_pkg, tkec_fifo,
// tkec_front and tkec_back.
// A result is visible (empty low) after its poll is registered in the slot queue,
// passes the combinational back lanes and is registered in the result queue.
// Throughput: one poll per cycle while the result queue has room (combinational lanes).
// Reset (rst_n low, asynchronous): queues empty, all slots idle, registers
// at button_enable = 0xFF and long_hold_ms = 1000.
module touch_key_event_classifier #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  tkec_pkg::poll_t               poll,
    output logic                          empty,
    input  logic                          pop,
    output tkec_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tkec_pkg::PADDR_W-1:0]  paddr,
    input  logic [tkec_pkg::PDATA_W-1:0]  pwdata,
    output logic [tkec_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tkec_pkg::*;

    cfg_t       cfg_reg;
    slot_item_t front_item, back_item;
    logic       mid_full, mid_empty, mid_pop;
    result_t    back_result;
    logic       back_push, out_full;
    logic       cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_enable <= ENABLE_RESET;
            cfg_reg.long_hold_ms  <= HOLD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[REG_IDX_BIT])
                REG_BUTTON_ENABLE: cfg_reg.button_enable <= pwdata[MAX_SLOTS-1:0];
                REG_LONG_HOLD:     cfg_reg.long_hold_ms  <= pwdata[HOLD_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_IDX_BIT])
            REG_BUTTON_ENABLE: prdata = PDATA_W'(cfg_reg.button_enable);
            REG_LONG_HOLD:     prdata = PDATA_W'(cfg_reg.long_hold_ms);
            default:           prdata = '0;
        endcase
    end

    // Front: classify the poll onto slots
    tkec_front #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_front (
        .cfg  (cfg_reg),
        .poll (poll),
        .item (front_item)
    );

    assign full = mid_full;

    // Queue between front and back
    tkec_fifo #(
        .WIDTH($bits(slot_item_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (back_item),
        .empty (mid_empty)
    );

    // Back: per-slot press tracking
    tkec_back #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item        (back_item),
        .item_valid  (!mid_empty),
        .out_full    (out_full),
        .item_pop    (mid_pop),
        .result      (back_result),
        .result_push (back_push)
    );

    // Result queue
    tkec_fifo #(
        .WIDTH($bits(result_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .din   (back_result),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule
